/* rtl/core/ntc_pkg.sv */
package ntc_pkg;

    // Default run limit: bytes in a row that match no punctuation rule
    localparam int RUN_LIMIT_DEF = 300;

    // Reciprocals for exact unsigned 32-bit division by 3 and by 5
    localparam logic [31:0] RECIP_3 = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP_5 = 32'hCCCC_CCCD;
    localparam int          SHIFT_3 = 33;
    localparam int          SHIFT_5 = 34;

    // Input beat
    typedef struct packed {
        logic [7:0] byte_in;
        logic [3:0] format_nibble;
    } ntc_in_t;

    // Result beat
    typedef struct packed {
        logic [15:0] ctx_mix_all;
        logic [15:0] ctx_class_punct_quote;
        logic [15:0] ctx_class_nest_run;
        logic [15:0] ctx_class_nest;
        logic [15:0] ctx_class_third_punct;
        logic [15:0] ctx_punct_nest;
        logic [15:0] ctx_change_quote;
        logic [19:0] ctx_class_format;
        logic [19:0] ctx_punct_format;
        logic [19:0] ctx_nest_format;
        logic [8:0]  mixer_select;
    } ntc_out_t;

    // Tracker state after the update for one beat, plus its side info
    typedef struct packed {
        logic [31:0] class_hist;
        logic [15:0] change_hist;
        logic [31:0] nest;
        logic [31:0] punct;
        logic [31:0] quote;
        logic [3:0]  fmt;
        logic        disabled;
    } ntc_snap_t;

    // Signed division by 3 or 5, truncating toward zero.
    // One 32x32 multiply by the reciprocal, then a fixed shift.
    function automatic logic [31:0] sdiv_3_5(input logic [31:0] v, input logic by_five);
        logic [31:0] mag;
        logic [31:0] recip;
        logic [63:0] prod;
        logic [31:0] q;
        mag   = v[31] ? (32'd0 - v) : v;
        recip = by_five ? RECIP_5 : RECIP_3;
        prod  = {32'd0, mag} * {32'd0, recip};
        q     = by_five ? 32'(prod >> SHIFT_5) : 32'(prod >> SHIFT_3);
        return v[31] ? (32'd0 - q) : q;
    endfunction

endpackage

/* rtl/core/text_nesting_context_tracker.sv */
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ----------------------------
// in        sink       in_valid / in_ready     in_data  (ntc_in_t)
// out       source     out_valid / out_ready  out_data (ntc_out_t)
// cfg       sink       cfg_we, no wait        cfg_wdata (model_disabled)
//
// One beat per cycle while out_ready holds; a result passes through the state
// register, then the result register.
// The state update is a single pass through the byte rules and one shared
// divide-by-3/5 multiplier; the result register holds another multiplier.
// rst_n clears all tracker state, the disable flag and both valid flags.
// A stalled result holds; in_ready drops only when both stages are full.
module text_nesting_context_tracker #(
    parameter int RUN_LIMIT = ntc_pkg::RUN_LIMIT_DEF,
    parameter int RUN_W     = $clog2(RUN_LIMIT + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntc_pkg::ntc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ntc_pkg::ntc_out_t out_data
);
    import ntc_pkg::*;

    logic             snap_valid;
    logic             snap_ready;
    ntc_snap_t        snap;
    logic [RUN_W-1:0] run;

    // State update stage
    ntc_state #(
        .RUN_LIMIT (RUN_LIMIT),
        .RUN_W     (RUN_W)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .run        (run)
    );

    // Context word stage
    ntc_ctx #(
        .RUN_W (RUN_W)
    ) u_ctx (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .run        (run),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

/* rtl/core/ntc_state.sv */
module ntc_state #(
    parameter int RUN_LIMIT = ntc_pkg::RUN_LIMIT_DEF,
    parameter int RUN_W     = $clog2(RUN_LIMIT + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  ntc_pkg::ntc_in_t  in_data,
    output logic              snap_valid,
    input  logic              snap_ready,
    output ntc_pkg::ntc_snap_t snap,
    output logic [RUN_W-1:0]  run
);
    import ntc_pkg::*;

    // Byte codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRC   = 8'h7B;
    localparam logic [7:0] CH_RBRC   = 8'h7D;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_ENQ    = 8'h05;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [RUN_W:0] RUN_MAX = (RUN_W + 1)'(RUN_LIMIT);

    // Character classes
    localparam logic [2:0] CLS_OTHER  = 3'd0;
    localparam logic [2:0] CLS_VOWEL  = 3'd1;
    localparam logic [2:0] CLS_LETTER = 3'd2;
    localparam logic [2:0] CLS_SEP    = 3'd3;
    localparam logic [2:0] CLS_DIGIT  = 3'd4;
    localparam logic [2:0] CLS_APOS   = 3'd6;
    localparam logic [2:0] CLS_BIT5   = 3'd7;

    logic [31:0]      class_hist_reg, class_hist_next;
    logic [15:0]      change_hist_reg, change_hist_next;
    logic [2:0]       last_class_reg, last_class_next;
    logic [31:0]      nest_reg, nest_next;
    logic [31:0]      punct_reg, punct_next;
    logic [31:0]      quote_reg, quote_next;
    logic [RUN_W-1:0] run_reg, run_next;
    logic [7:0]       prev_byte_reg, prev_byte_next;
    logic [3:0]       fmt_reg;
    logic             dis_item_reg;
    logic             disabled_reg;
    logic             valid_reg, valid_next;

    logic             accept;
    logic             update;
    logic [7:0]       c;
    logic [7:0]       lc;
    logic [2:0]       cls;
    logic [31:0]      quote_div;
    logic             matched;
    logic [31:0]      nest_upd, punct_upd, quote_upd;
    logic [RUN_W:0]   run_full;

    assign in_ready = !valid_reg || snap_ready;
    assign accept   = in_valid && in_ready;
    assign update   = accept && !disabled_reg;
    assign c        = in_data.byte_in;

    // Character class
    always_comb
    begin
        lc = ((c >= 8'h41) && (c <= 8'h5A)) ? (c + 8'd32) : c;
        if (lc == 8'h61 || lc == 8'h65 || lc == 8'h69 || lc == 8'h6F || lc == 8'h75)
        begin
            cls = CLS_VOWEL;
        end
        else if (((lc >= 8'h61) && (lc <= 8'h7A)) || (c > 8'd128))
        begin
            cls = CLS_LETTER;
        end
        else if (lc == CH_SPACE || lc == CH_DOT || lc == CH_COMMA || lc == CH_LF
                 || lc == CH_ENQ)
        begin
            cls = CLS_SEP;
        end
        else if ((lc >= 8'h30) && (lc <= 8'h39))
        begin
            cls = CLS_DIGIT;
        end
        else if (lc == CH_APOS)
        begin
            cls = CLS_APOS;
        end
        else
        begin
            cls = c[5] ? CLS_BIT5 : CLS_OTHER;
        end
    end

    // Shared divider for '>' (by 5) and ';' (by 3)
    assign quote_div = sdiv_3_5(quote_reg, c == CH_GT);

    // Punctuation rules
    always_comb
    begin
        nest_upd  = nest_reg;
        punct_upd = punct_reg;
        quote_upd = quote_reg;
        matched   = 1'b1;
        case (c)
            CH_SPACE:  quote_upd = 32'd0;
            CH_LPAR:   nest_upd  = nest_reg + 32'd31;
            CH_RPAR:   nest_upd  = nest_reg - 32'd31;
            CH_LBRK:   nest_upd  = nest_reg + 32'd11;
            CH_RBRK:   nest_upd  = nest_reg - 32'd11;
            CH_LT:
            begin
                nest_upd  = nest_reg + 32'd23;
                quote_upd = quote_reg + 32'd34;
            end
            CH_GT:
            begin
                nest_upd  = nest_reg - 32'd23;
                quote_upd = quote_div;
            end
            CH_COLON:  punct_upd = 32'd20;
            CH_LBRC:   nest_upd  = nest_reg + 32'd17;
            CH_RBRC:   nest_upd  = nest_reg - 32'd17;
            CH_PIPE:   punct_upd = punct_reg + 32'd223;
            CH_DQUOTE: punct_upd = punct_reg + 32'h40;
            CH_APOS:   punct_upd = punct_reg + 32'h42;
            CH_ENQ, CH_LF:
            begin
                punct_upd = 32'd0;
                quote_upd = 32'd0;
            end
            CH_DOT, CH_BANG, CH_QMARK: punct_upd = 32'd0;
            CH_HASH:   punct_upd = punct_reg + 32'h08;
            CH_PCT:    punct_upd = punct_reg + 32'h76;
            CH_DOLLAR: punct_upd = punct_reg + 32'h45;
            CH_STAR:   punct_upd = punct_reg + 32'h35;
            CH_DASH:   punct_upd = punct_reg + 32'h03;
            CH_AT:     punct_upd = punct_reg + 32'h72;
            CH_AMP:    quote_upd = quote_reg + 32'h12;
            CH_SEMI:   quote_upd = quote_div;
            CH_BSLASH: punct_upd = punct_reg + 32'h29;
            CH_SLASH:
            begin
                punct_upd = punct_reg + 32'h11;
                // slash right after '<' opens a closing tag
                if (prev_byte_reg == CH_LT)
                begin
                    quote_upd = quote_reg + 32'd74;
                end
            end
            CH_EQ:     punct_upd = punct_reg + 32'd87;
            default:   matched   = 1'b0;
        endcase
    end

    // Run counter and next state
    always_comb
    begin
        run_full         = matched ? '0 : ({1'b0, run_reg} + (RUN_W + 1)'(1));
        class_hist_next  = class_hist_reg;
        change_hist_next = change_hist_reg;
        last_class_next  = last_class_reg;
        nest_next        = nest_reg;
        punct_next       = punct_reg;
        quote_next       = quote_reg;
        run_next         = run_reg;
        prev_byte_next   = prev_byte_reg;
        if (update)
        begin
            class_hist_next = {class_hist_reg[28:0], cls};
            if (cls != last_class_reg)
            begin
                change_hist_next = {change_hist_reg[12:0], cls};
                last_class_next  = cls;
            end
            prev_byte_next = c;
            if (run_full > RUN_MAX)
            begin
                // too long without punctuation: forget it all
                nest_next  = 32'd0;
                punct_next = 32'd0;
                quote_next = 32'd0;
                run_next   = '0;
            end
            else
            begin
                nest_next  = nest_upd;
                punct_next = punct_upd;
                quote_next = quote_upd;
                run_next   = run_full[RUN_W-1:0];
            end
        end
    end

    assign valid_next = accept || (valid_reg && !snap_ready);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= 1'b0;
            disabled_reg    <= 1'b0;
            class_hist_reg  <= '0;
            change_hist_reg <= '0;
            last_class_reg  <= '0;
            nest_reg        <= '0;
            punct_reg       <= '0;
            quote_reg       <= '0;
            run_reg         <= '0;
            prev_byte_reg   <= '0;
        end
        else
        begin
            valid_reg       <= valid_next;
            if (cfg_we)
            begin
                disabled_reg <= cfg_wdata;
            end
            class_hist_reg  <= class_hist_next;
            change_hist_reg <= change_hist_next;
            last_class_reg  <= last_class_next;
            nest_reg        <= nest_next;
            punct_reg       <= punct_next;
            quote_reg       <= quote_next;
            run_reg         <= run_next;
            prev_byte_reg   <= prev_byte_next;
        end
    end

    // Per-beat side info
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg      <= in_data.format_nibble;
            dis_item_reg <= disabled_reg;
        end
    end

    assign snap_valid       = valid_reg;
    assign snap.class_hist  = class_hist_reg;
    assign snap.change_hist = change_hist_reg;
    assign snap.nest        = nest_reg;
    assign snap.punct       = punct_reg;
    assign snap.quote       = quote_reg;
    assign snap.fmt         = fmt_reg;
    assign snap.disabled    = dis_item_reg;
    assign run              = run_reg;

endmodule

/* rtl/core/ntc_ctx.sv */
module ntc_ctx #(
    parameter int RUN_W = $clog2(ntc_pkg::RUN_LIMIT_DEF + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               snap_valid,
    output logic               snap_ready,
    input  ntc_pkg::ntc_snap_t snap,
    input  logic [RUN_W-1:0]   run,
    output logic               out_valid,
    input  logic               out_ready,
    output ntc_pkg::ntc_out_t  out_data
);
    import ntc_pkg::*;

    logic        valid_reg, valid_next;
    ntc_out_t    data_reg, data_next;
    logic        load;
    logic [15:0] vh, ph, nh, qh, ch, rh;
    logic [31:0] third;

    assign snap_ready = !valid_reg || out_ready;
    assign load       = snap_valid && snap_ready;

    // Low 16 bits are all the mod-65536 sums need
    assign vh    = snap.class_hist[15:0];
    assign ph    = snap.punct[15:0];
    assign nh    = snap.nest[15:0];
    assign qh    = snap.quote[15:0];
    assign ch    = snap.change_hist;
    assign rh    = 16'(run);
    assign third = sdiv_3_5(snap.class_hist, 1'b0);

    // Context words
    always_comb
    begin
        data_next = '0;
        if (!snap.disabled)
        begin
            data_next.ctx_mix_all           = vh * 16'd3 + ph * 16'd77 + nh * 16'd373 + qh;
            data_next.ctx_class_punct_quote = vh * 16'd31 + ph * 16'd27 + qh * 16'd281;
            data_next.ctx_class_nest_run    = vh * 16'd13 + nh * 16'd271 + qh + rh;
            data_next.ctx_class_nest        = vh * 16'd13 + nh;
            data_next.ctx_class_third_punct = third[15:0] + ph;
            data_next.ctx_punct_nest        = ph * 16'd17 + nh * 16'd7;
            data_next.ctx_change_quote      = ch * 16'd7 + qh;
            data_next.ctx_class_format      = {snap.fmt, vh};
            data_next.ctx_punct_format      = {snap.fmt, 16'(ph * 16'd3)};
            data_next.ctx_nest_format       = {snap.fmt, nh};
            data_next.mixer_select          = snap.class_hist[8:0];
        end
    end

    assign valid_next = load || (valid_reg && !out_ready);

    // Result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
